FILE: rtl/psch_pkg.sv
// Shared types and field widths of the preemptive priority scheduler.
package psch_pkg;

  localparam int SLOT_W    = 3;
  localparam int ARRIVAL_W = 16;
  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int OUT_W     = 16;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

endpackage

FILE: rtl/psch_select.sv
// Registered-free compare tree: lowest priority number among eligible slots.
module psch_select
  import psch_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic [SLOTS-1:0]           elig_i,
  input  logic [PRIO_W-1:0]          prio_i [SLOTS],
  output logic                       found_o,
  output logic [$clog2(SLOTS)-1:0]   idx_o,
  output logic [PRIO_W-1:0]          prio_o
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LEAVES = 1 << IDX_W;

  logic              node_found [2*LEAVES];
  logic [IDX_W-1:0]  node_idx   [2*LEAVES];
  logic [PRIO_W-1:0] node_prio  [2*LEAVES];

  always_comb begin
    node_found[0] = 1'b0;
    node_idx[0]   = '0;
    node_prio[0]  = '0;
    // Leaves: one per slot, padding leaves never win.
    for (int i = 0; i < LEAVES; i++) begin
      if (i < SLOTS) begin
        node_found[LEAVES+i] = elig_i[i];
        node_prio[LEAVES+i]  = prio_i[i];
      end else begin
        node_found[LEAVES+i] = 1'b0;
        node_prio[LEAVES+i]  = '0;
      end
      node_idx[LEAVES+i] = IDX_W'(i);
    end
    // Merge pairs; the left child holds lower indexes, so it wins ties.
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (node_found[2*n+1] &&
          (!node_found[2*n] || node_prio[2*n+1] < node_prio[2*n])) begin
        node_found[n] = 1'b1;
        node_idx[n]   = node_idx[2*n+1];
        node_prio[n]  = node_prio[2*n+1];
      end else begin
        node_found[n] = node_found[2*n];
        node_idx[n]   = node_idx[2*n];
        node_prio[n]  = node_prio[2*n];
      end
    end
  end

  assign found_o = node_found[1];
  assign idx_o   = node_idx[1];
  assign prio_o  = node_prio[1];

endmodule

FILE: rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler with its slot table.
//
// Usage:
//   A word is accepted at a rising edge with start_i high and busy_o low.
//   busy_o is always low, so one word can enter on every cycle.
//   action_i = ACT_LOAD writes slot_i with arrival_i, burst_i and
//   priority_req_i and sets its remaining work to burst_i; no result.
//   action_i = ACT_TICK runs one time unit and yields exactly one result.
//   Results appear on the result ports for one cycle with strobe_o high;
//   the receiver cannot hold them off.
// Pipeline and throughput:
//   A tick word's result passes through the input register, then the result
//   register, before it reaches the ports. One word per cycle sustained; the
//   state update of each word completes before the next word is evaluated.
// Selection:
//   A compare tree over all slots picks the lowest priority number among
//   slots that have arrived and have work left; the running slot keeps the
//   unit on a tie, otherwise the lowest index wins.
// Reset:
//   rst_ni clears the time, the remaining work of every slot and the
//   running-slot marker; the block accepts words as soon as reset is released.
module preemptive_priority_scheduler
  import psch_pkg::*;
#(
  parameter int SLOTS     = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 action_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [ARRIVAL_W-1:0] arrival_i,
  input  logic [BURST_W-1:0]   burst_i,
  input  logic [PRIO_W-1:0]    priority_req_i,
  output logic                 strobe_o,
  output logic                 idle_o,
  output logic [SLOT_W-1:0]    running_o,
  output logic                 finished_o,
  output logic [OUT_W-1:0]     completion_time_o,
  output logic [OUT_W-1:0]     waiting_time_o,
  output logic [OUT_W-1:0]     turnaround_time_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CMP_W = (TIME_BITS > OUT_W) ? TIME_BITS : OUT_W;
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // Input register
  logic                 in_valid_q;
  action_e              in_action_q;
  logic [SLOT_W-1:0]    in_slot_q;
  logic [ARRIVAL_W-1:0] in_arrival_q;
  logic [BURST_W-1:0]   in_burst_q;
  logic [PRIO_W-1:0]    in_prio_q;

  // Slot table and scheduler state
  logic [ARRIVAL_W-1:0] arrival_q   [SLOTS];
  logic [BURST_W-1:0]   burst_q     [SLOTS];
  logic [BURST_W-1:0]   remaining_q [SLOTS];
  logic [PRIO_W-1:0]    prio_q      [SLOTS];
  logic [IDX_W-1:0]     cur_slot_q, cur_slot_d;
  logic                 cur_valid_q, cur_valid_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  // Result register
  logic                 strobe_q;
  logic                 idle_q;
  logic [SLOT_W-1:0]    running_q;
  logic                 finished_q;
  logic [OUT_W-1:0]     completion_q;
  logic [OUT_W-1:0]     waiting_q;
  logic [OUT_W-1:0]     turnaround_q;

  logic                 accept;
  logic                 load_en, tick_en, run_en;
  logic [EXT_W-1:0]     slot_ext;
  logic [IDX_W-1:0]     load_idx;
  logic                 load_ok;
  logic [SLOTS-1:0]     elig;
  logic                 sel_found;
  logic [IDX_W-1:0]     sel_idx;
  logic [PRIO_W-1:0]    sel_prio;
  logic [IDX_W-1:0]     pick;
  logic [EXT_W-1:0]     pick_ext;
  logic [BURST_W-1:0]   rem_dec;
  logic [CMP_W-1:0]     done_w, arr_w, burst_w, tat_w, wait_w;
  logic [OUT_W-1:0]     tat_sat, wait_sat, completion_sat;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Capture each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_action_q  <= action_e'(action_i);
      in_slot_q    <= slot_i;
      in_arrival_q <= arrival_i;
      in_burst_q   <= burst_i;
      in_prio_q    <= priority_req_i;
    end
  end

  // Load decode: drop writes to slots past the table
  assign slot_ext = EXT_W'(in_slot_q);
  assign load_idx = slot_ext[IDX_W-1:0];
  assign load_ok  = {1'b0, slot_ext} < (EXT_W + 1)'(SLOTS);
  assign load_en  = in_valid_q && (in_action_q == ACT_LOAD) && load_ok;
  assign tick_en  = in_valid_q && (in_action_q == ACT_TICK);

  // Eligible: work left and already arrived
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      elig[i] = (remaining_q[i] != '0) &&
                (CMP_W'(arrival_q[i]) <= CMP_W'(now_q));
    end
  end

  psch_select #(
    .SLOTS (SLOTS)
  ) u_select (
    .elig_i  (elig),
    .prio_i  (prio_q),
    .found_o (sel_found),
    .idx_o   (sel_idx),
    .prio_o  (sel_prio)
  );

  // The running slot holds the unit when it ties the best priority
  always_comb begin
    if (sel_found && cur_valid_q && elig[cur_slot_q] && (prio_q[cur_slot_q] == sel_prio)) begin
      pick = cur_slot_q;
    end else begin
      pick = sel_idx;
    end
  end

  assign run_en   = tick_en && sel_found;
  assign rem_dec  = remaining_q[pick] - BURST_W'(1);
  assign pick_ext = EXT_W'(pick);

  // Advance time, saturating at the top
  assign now_d = (now_q == '1) ? now_q : now_q + TIME_BITS'(1);

  // Completion statistics, all against the time after this tick
  assign done_w  = CMP_W'(now_d);
  assign arr_w   = CMP_W'(arrival_q[pick]);
  assign burst_w = CMP_W'(burst_q[pick]);
  assign tat_w   = done_w - arr_w;
  assign wait_w  = tat_w - burst_w;

  assign completion_sat = (done_w > CMP_W'(OUT_MAX)) ? OUT_MAX : done_w[OUT_W-1:0];
  assign tat_sat  = (done_w < arr_w) ? '0 :
                    (tat_w > CMP_W'(OUT_MAX)) ? OUT_MAX : tat_w[OUT_W-1:0];
  assign wait_sat = ((done_w < arr_w) || (tat_w < burst_w)) ? '0 :
                    (wait_w > CMP_W'(OUT_MAX)) ? OUT_MAX : wait_w[OUT_W-1:0];

  always_comb begin
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    if (load_en) begin
      // A reloaded running slot loses its tie advantage
      if (cur_valid_q && (cur_slot_q == load_idx)) begin
        cur_valid_d = 1'b0;
      end
    end else if (tick_en) begin
      if (sel_found) begin
        cur_slot_d  = pick;
        cur_valid_d = (rem_dec != '0);
      end else begin
        cur_valid_d = 1'b0;
      end
    end
  end

  // Table payload
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      arrival_q[load_idx] <= in_arrival_q;
      burst_q[load_idx]   <= in_burst_q;
      prio_q[load_idx]    <= in_prio_q;
    end
  end

  // Remaining work doubles as the slot's occupied flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        remaining_q[i] <= '0;
      end
    end else if (load_en) begin
      remaining_q[load_idx] <= in_burst_q;
    end else if (run_en) begin
      remaining_q[pick] <= rem_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      now_q       <= '0;
      strobe_q    <= 1'b0;
    end else begin
      cur_slot_q  <= cur_slot_d;
      cur_valid_q <= cur_valid_d;
      if (tick_en) begin
        now_q <= now_d;
      end
      strobe_q <= tick_en;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (tick_en) begin
      idle_q       <= !sel_found;
      running_q    <= sel_found ? pick_ext[SLOT_W-1:0] : '0;
      finished_q   <= sel_found && (rem_dec == '0);
      completion_q <= completion_sat;
      waiting_q    <= (sel_found && (rem_dec == '0)) ? wait_sat : '0;
      turnaround_q <= (sel_found && (rem_dec == '0)) ? tat_sat : '0;
    end
  end

  assign strobe_o          = strobe_q;
  assign idle_o            = idle_q;
  assign running_o         = running_q;
  assign finished_o        = finished_q;
  assign completion_time_o = completion_q;
  assign waiting_time_o    = waiting_q;
  assign turnaround_time_o = turnaround_q;

endmodule

FILE: tb/sv/tb_preemptive_priority_scheduler.sv
// Self-checking testbench of the preemptive priority scheduler.
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;
  import psch_pkg::*;

  localparam int SLOTS     = 8;
  localparam int TIME_BITS = 16;
  // Cycles without any accepted word or result word before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Result register sits right behind the input register.
  localparam int DRAIN_CYCLES = 6;

  // One command word as the driver presents it.
  typedef struct packed {
    action_e              action;
    logic [SLOT_W-1:0]    slot;
    logic [ARRIVAL_W-1:0] arrival;
    logic [BURST_W-1:0]   burst;
    logic [PRIO_W-1:0]    prio;
    logic                 wait_drain;  // hold this word until no tick result is due
    logic [6:0]           gap_pct;     // chance in percent to leave start low
  } sched_word_t;

  // One tick outcome as the block reports it.
  typedef struct packed {
    logic              idle;
    logic [SLOT_W-1:0] running;
    logic              finished;
    logic [OUT_W-1:0]  completion;
    logic [OUT_W-1:0]  waiting;
    logic [OUT_W-1:0]  turnaround;
  } tick_outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 start_i        = 1'b0;
  logic                 action_i       = 1'b0;
  logic [SLOT_W-1:0]    slot_i         = '0;
  logic [ARRIVAL_W-1:0] arrival_i      = '0;
  logic [BURST_W-1:0]   burst_i        = '0;
  logic [PRIO_W-1:0]    priority_req_i = '0;

  logic                 busy_o;
  logic                 strobe_o;
  logic                 idle_o;
  logic [SLOT_W-1:0]    running_o;
  logic                 finished_o;
  logic [OUT_W-1:0]     completion_time_o;
  logic [OUT_W-1:0]     waiting_time_o;
  logic [OUT_W-1:0]     turnaround_time_o;

  preemptive_priority_scheduler #(
    .SLOTS    (SLOTS),
    .TIME_BITS(TIME_BITS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .slot_i           (slot_i),
    .arrival_i        (arrival_i),
    .burst_i          (burst_i),
    .priority_req_i   (priority_req_i),
    .strobe_o         (strobe_o),
    .idle_o           (idle_o),
    .running_o        (running_o),
    .finished_o       (finished_o),
    .completion_time_o(completion_time_o),
    .waiting_time_o   (waiting_time_o),
    .turnaround_time_o(turnaround_time_o)
  );

  // Words still to be sent, and tick outcomes still to be seen.
  sched_word_t   pending_words[$];
  tick_outcome_t due_outcomes[$];
  int            err_cnt   = 0;
  int            stall_cnt = 0;

  // Shadow copy of the scheduler state, advanced once per accepted word.
  logic [ARRIVAL_W-1:0] arr_tab  [SLOTS];
  logic [BURST_W-1:0]   burst_tab[SLOTS];
  logic [BURST_W-1:0]   left_tab [SLOTS];
  logic [PRIO_W-1:0]    prio_tab [SLOTS];
  logic [SLOT_W-1:0]    cur_slot  = '0;
  logic                 cur_valid = 1'b0;
  logic [TIME_BITS-1:0] now_t     = '0;

  // Stimulus build state: tick count seen by the generator and current gap.
  logic [TIME_BITS-1:0] gen_now = '0;
  int                   gen_gap = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted word to the shadow state; queue the outcome of a tick.
  task automatic schedule_word(input sched_word_t w);
    int            pick;
    bit            found;
    logic [16:0]   tat;
    tick_outcome_t o;
    if (w.action == ACT_LOAD) begin
      arr_tab[w.slot]   = w.arrival;
      burst_tab[w.slot] = w.burst;
      left_tab[w.slot]  = w.burst;
      prio_tab[w.slot]  = w.prio;
      // Reloading the running slot drops its claim on a tie.
      if (cur_valid && cur_slot == w.slot) cur_valid = 1'b0;
    end else begin
      found = 1'b0;
      pick  = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (left_tab[s] != 0 && arr_tab[s] <= now_t &&
            (!found || prio_tab[s] < prio_tab[pick])) begin
          pick  = s;
          found = 1'b1;
        end
      end
      // The running slot keeps the unit when it ties with the winner.
      if (found && cur_valid && left_tab[cur_slot] != 0 && arr_tab[cur_slot] <= now_t &&
          prio_tab[cur_slot] == prio_tab[pick]) begin
        pick = cur_slot;
      end
      // Time saturates at its top value.
      if (now_t != '1) now_t = now_t + 1'b1;
      o = '0;
      o.completion = now_t;
      if (!found) begin
        o.idle    = 1'b1;
        cur_valid = 1'b0;
      end else begin
        left_tab[pick] = left_tab[pick] - 1'b1;
        o.running      = pick[SLOT_W-1:0];
        cur_slot       = pick[SLOT_W-1:0];
        cur_valid      = (left_tab[pick] != 0);
        if (left_tab[pick] == 0) begin
          o.finished = 1'b1;
          if (now_t >= arr_tab[pick]) begin
            tat          = now_t - arr_tab[pick];
            o.turnaround = tat[OUT_W-1:0];
            o.waiting    = (tat >= burst_tab[pick]) ? OUT_W'(tat - burst_tab[pick]) : '0;
          end
        end
      end
      due_outcomes.push_back(o);
    end
  endtask

  task automatic push_load(input int slot, input int arrival, input int burst,
                           input int prio, input bit hold);
    sched_word_t w;
    w.action     = ACT_LOAD;
    w.slot       = slot[SLOT_W-1:0];
    w.arrival    = arrival[ARRIVAL_W-1:0];
    w.burst      = burst[BURST_W-1:0];
    w.prio       = prio[PRIO_W-1:0];
    w.wait_drain = hold;
    w.gap_pct    = gen_gap[6:0];
    pending_words.push_back(w);
  endtask

  // Tick words carry random don't-care payload so those bits toggle too.
  task automatic push_tick(input bit hold);
    sched_word_t w;
    w.action     = ACT_TICK;
    w.slot       = SLOT_W'($urandom());
    w.arrival    = ARRIVAL_W'($urandom());
    w.burst      = BURST_W'($urandom());
    w.prio       = PRIO_W'($urandom());
    w.wait_drain = hold;
    w.gap_pct    = gen_gap[6:0];
    pending_words.push_back(w);
    if (gen_now != '1) gen_now = gen_now + 1'b1;
  endtask

  // Mostly arrivals near the present, short bursts and few priority levels,
  // so that ties, preemption and completions happen often.
  task automatic push_random_word(input bit hold);
    int arrival;
    int burst;
    int prio;
    if ($urandom_range(99) < 30) begin
      arrival = ($urandom_range(15) == 0) ? $urandom_range(16'hFFFF)
                                          : gen_now + $urandom_range(20) - 3;
      if (arrival < 0) arrival = 0;
      if (arrival > 16'hFFFF) arrival = 16'hFFFF;
      case ($urandom_range(15))
        0:       burst = 0;
        1:       burst = $urandom_range(16'hFFFF);
        default: burst = $urandom_range(12, 1);
      endcase
      prio = ($urandom_range(7) == 0) ? $urandom_range(8'hFF) : $urandom_range(7);
      push_load($urandom_range(SLOTS - 1), arrival, burst, prio, hold);
    end else begin
      push_tick(hold);
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Driver: advance the queue on acceptance, then present the next word or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        schedule_word(pending_words.pop_front());
      end
      if (start_i && busy_o) begin
        // Hold the word until the block takes it.
        start_i <= 1'b1;
      end else if (pending_words.size() == 0) begin
        start_i <= 1'b0;
      end else if (pending_words[0].wait_drain && due_outcomes.size() != 0) begin
        start_i <= 1'b0;
      end else if ($urandom_range(99) < pending_words[0].gap_pct) begin
        start_i <= 1'b0;
      end else begin
        start_i        <= 1'b1;
        action_i       <= pending_words[0].action;
        slot_i         <= pending_words[0].slot;
        arrival_i      <= pending_words[0].arrival;
        burst_i        <= pending_words[0].burst;
        priority_req_i <= pending_words[0].prio;
      end
    end
  end

  // Monitor: compare each result word with the oldest outcome; run the watchdog.
  always @(posedge clk_i) begin
    tick_outcome_t o;
    if (rst_ni) begin
      if (strobe_o) begin
        if (due_outcomes.size() == 0) begin
          $display("%0t: result word with no outcome due, running %0d", $time, running_o);
          err_cnt++;
        end else begin
          o = due_outcomes.pop_front();
          check_field("idle", o.idle, idle_o);
          check_field("running", o.running, running_o);
          check_field("finished", o.finished, finished_o);
          check_field("completion_time", o.completion, completion_time_o);
          check_field("waiting_time", o.waiting, waiting_time_o);
          check_field("turnaround_time", o.turnaround, turnaround_time_o);
        end
      end
      if (strobe_o || (start_i && !busy_o)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d words and %0d outcomes left", $time,
                 pending_words.size(), due_outcomes.size());
        $display("tb_preemptive_priority_scheduler: errors");
        $finish;
      end
    end
  end

  initial begin
    int gap_by_phase[4];
    gap_by_phase = '{0, 48, 0, 22};
    for (int s = 0; s < SLOTS; s++) begin
      arr_tab[s]   = '0;
      burst_tab[s] = '0;
      left_tab[s]  = '0;
      prio_tab[s]  = '0;
    end

    // Directed part: tie kept by the running slot, preemption, completion,
    // reload of the running slot, empty slot, idle ticks, field extremes.
    gen_gap = 0;
    push_load(0, 0, 3, 5, 1'b0);
    push_load(1, 1, 2, 5, 1'b0);
    push_load(2, 2, 1, 0, 1'b0);
    push_load(7, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
    repeat (5) push_tick(1'b0);
    push_load(1, 0, 2, 5, 1'b0);
    push_load(0, 0, 1, 5, 1'b0);
    repeat (4) push_tick(1'b0);
    push_load(3, 0, 0, 0, 1'b0);
    repeat (2) push_tick(1'b0);
    push_load(4, 0, 1, 8'hFF, 1'b0);
    push_load(5, gen_now + 1, 2, 0, 1'b0);
    repeat (4) push_tick(1'b0);

    // Random part in phases; each phase opens after the previous has drained.
    for (int ph = 0; ph < 4; ph++) begin
      gen_gap = gap_by_phase[ph];
      for (int i = 0; i < 282; i++) push_random_word(i == 0);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to go in and every outcome to come back, then drain.
    while (pending_words.size() != 0 || due_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_preemptive_priority_scheduler: clean");
    end else begin
      $display("tb_preemptive_priority_scheduler: errors");
    end
    $finish;
  end

endmodule
